>>> rtl/block_transposition_cipher_macros.svh
// Assertion macros used by the block transposition cipher RTL.
// Needs nothing but the clock, reset and expressions handed in by the caller.
`ifndef BLOCK_TRANSPOSITION_CIPHER_MACROS_SVH
`define BLOCK_TRANSPOSITION_CIPHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTC_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/btc_pkg.sv
// Package for the block transposition cipher: sizes, codes, constants, shared types.
// Used by the interfaces and every RTL module of the block; depends on nothing.
`default_nettype none

package btc_pkg;

   // Block buffer capacity and derived widths
   localparam int MAX_BLOCK    = 16;
   localparam int POS_W        = $clog2(MAX_BLOCK);
   localparam int SIZE_W       = $clog2(MAX_BLOCK + 1);
   localparam int KEY_ENTRIES  = 16;
   localparam int KEY_ENTRY_W  = 4;
   localparam int KEY_IDX_W    = $clog2(KEY_ENTRIES);
   localparam int CMP_W        = ((SIZE_W > KEY_ENTRY_W) ? SIZE_W : KEY_ENTRY_W) + 1;

   // Configuration port
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = KEY_ENTRIES * KEY_ENTRY_W;
   localparam int CSR_SIZE_W   = 5;

   // Padding generator
   localparam int LFSR_W       = 16;
   localparam int RECIP_W      = 13;
   localparam int PROD_W       = LFSR_W + RECIP_W;
   localparam int MOD_SHIFT    = 17;

   // Transaction queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef logic [7:0]                                 char_type;
   typedef logic [SIZE_W-1:0]                          size_type;
   typedef logic [POS_W-1:0]                           pos_type;
   typedef logic [CMP_W-1:0]                           cmp_type;
   typedef logic [KEY_ENTRY_W-1:0]                     key_entry_type;
   typedef logic [KEY_IDX_W-1:0]                       key_idx_type;
   typedef logic [KEY_ENTRIES-1:0][KEY_ENTRY_W-1:0]    key_type;
   typedef logic [LFSR_W-1:0]                          lfsr_type;
   typedef logic [PROD_W-1:0]                          prod_type;
   typedef logic [CSR_INDEX_W-1:0]                     csr_index_type;
   typedef logic [CSR_DATA_W-1:0]                      csr_data_type;
   typedef logic [CSR_SIZE_W-1:0]                      csr_size_type;
   typedef logic [QPTR_W-1:0]                          qptr_type;
   typedef logic [QCNT_W-1:0]                          qcnt_type;

   // Register indexes
   localparam csr_index_type REG_BLOCK_SIZE    = 2'd0;
   localparam csr_index_type REG_KEY_POSITIONS = 2'd1;
   localparam csr_index_type REG_PAD_SEED      = 2'd2;

   // Register reset values
   localparam csr_size_type  BLOCK_SIZE_RESET  = 5'd5;
   localparam key_type       KEY_RESET         = 64'hFEDC_BA98_7654_3210;
   localparam lfsr_type      SEED_RESET        = 16'h0001;

   // Character codes
   localparam char_type CHAR_SPACE   = 8'h20;
   localparam char_type CHAR_NEWLINE = 8'h0A;
   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_UPPER_Z = 8'h5A;
   localparam char_type CASE_OFFSET  = 8'd32;
   localparam char_type PAD_BASE     = 8'd97;

   // Pad letter arithmetic: Galois taps and mod-26 by reciprocal (2^17 / 26)
   localparam lfsr_type           LFSR_TAPS = 16'hB400;
   localparam lfsr_type           PAD_RADIX = 16'd26;
   localparam logic [RECIP_W-1:0] MOD_RECIP = 13'd5041;

   // One classified transaction handed from front to back
   typedef struct packed {
      logic     kept;
      logic     eot;
      char_type ch;
   } item_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // Live configuration handed to the back end
   typedef struct packed {
      size_type size;
      key_type  key;
      logic     seed_load;
      lfsr_type seed;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_EMIT,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

>>> rtl/btc_intf.sv
// Channel interfaces of the block transposition cipher: text in, cipher out, register writes.
// Depends on btc_pkg for payload types.
`default_nettype none

interface btc_req_if;
   logic               valid;
   logic               ready;
   btc_pkg::char_type  in_char;
   logic               end_of_text;

   modport source (output valid, output in_char, output end_of_text, input ready);
   modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface btc_rsp_if;
   logic               valid;
   logic               ready;
   btc_pkg::char_type  out_char;
   logic               last_in_block;
   logic               last_of_message;

   modport source (output valid, output out_char, output last_in_block,
                   output last_of_message, input ready);
   modport sink   (input valid, input out_char, input last_in_block,
                   input last_of_message, output ready);
endinterface

interface btc_csr_if;
   logic                    valid;
   logic                    ready;
   btc_pkg::csr_index_type  index;
   btc_pkg::csr_data_type   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/btc_front.sv
// Front end: accepts text transactions, drops blanks, folds capitals, tags end of text.
// Depends on btc_pkg and btc_req_if; feeds btc_queue.
`default_nettype none

module btc_front (
   btc_req_if.sink                   req,
   input  btc_pkg::queue_status_type q_status,
   output logic                      q_push,
   output btc_pkg::item_type         q_item
);

   logic drop;
   logic upper;

   // Classify the incoming byte
   always_comb begin
      drop  = (req.in_char == btc_pkg::CHAR_SPACE) || (req.in_char == btc_pkg::CHAR_NEWLINE);
      upper = (req.in_char >= btc_pkg::CHAR_UPPER_A) && (req.in_char <= btc_pkg::CHAR_UPPER_Z);
      q_item.kept = !drop;
      q_item.eot  = req.end_of_text;
      q_item.ch   = upper ? (req.in_char + btc_pkg::CASE_OFFSET) : req.in_char;
   end

   // Blanks without end of text leave no work behind, so they are not queued
   assign req.ready = !q_status.full;
   assign q_push    = req.valid && !q_status.full && (!drop || req.end_of_text);

endmodule

`default_nettype wire

>>> rtl/btc_queue.sv
// Short transaction queue between the front end and the block engine.
// Depends on btc_pkg for the entry type and depth.
`default_nettype none

module btc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  btc_pkg::item_type         push_item,
   input  logic                      pop,
   output btc_pkg::item_type         head,
   output btc_pkg::queue_status_type status
);

   btc_pkg::item_type entries_ff [btc_pkg::QUEUE_DEPTH];
   btc_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   btc_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   btc_pkg::qcnt_type count_ff,  count_in;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == btc_pkg::qptr_type'(btc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + btc_pkg::qptr_type'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == btc_pkg::qptr_type'(btc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + btc_pkg::qptr_type'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + btc_pkg::qcnt_type'(1);
         2'b01:   count_in = count_ff - btc_pkg::qcnt_type'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == btc_pkg::qcnt_type'(btc_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> rtl/btc_back.sv
// Block engine: places kept bytes by key, pads partial blocks, emits blocks in position order.
// Depends on btc_pkg, btc_rsp_if and the assertion macros; fed by btc_queue.
`default_nettype none
`include "block_transposition_cipher_macros.svh"

module btc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  btc_pkg::cfg_type          cfg,
   input  btc_pkg::queue_status_type q_status,
   input  btc_pkg::item_type         q_head,
   output logic                      q_pop,
   btc_rsp_if.source                 rsp
);

   btc_pkg::state_type  state_ff, state_in;
   btc_pkg::size_type   fill_ff,  fill_in;
   btc_pkg::pos_type    pos_ff,   pos_in;
   btc_pkg::lfsr_type   lfsr_ff,  lfsr_in;
   btc_pkg::char_type   blk_mem_ff [btc_pkg::MAX_BLOCK];
   btc_pkg::char_type   blk_mem_in [btc_pkg::MAX_BLOCK];
   logic [btc_pkg::MAX_BLOCK-1:0] vld_ff, vld_in;
   btc_pkg::item_type   cur_ff,   cur_in;
   logic                last_ff,  last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   btc_pkg::char_type   rsp_char_ff,  rsp_char_in;
   logic                rsp_blk_ff,   rsp_blk_in;
   logic                rsp_msg_ff,   rsp_msg_in;

   btc_pkg::lfsr_type      lfsr_nx;
   btc_pkg::prod_type      prod;
   btc_pkg::lfsr_type      quot;
   btc_pkg::lfsr_type      quot_x26;
   btc_pkg::lfsr_type      rem;
   btc_pkg::lfsr_type      rem_fix;
   btc_pkg::char_type      pad_char;

   btc_pkg::cmp_type       fill_inc;
   logic                   fill_lt;
   logic                   at_end;
   logic                   slot_free;
   logic                   emit_go;
   logic                   wr_en;
   btc_pkg::key_idx_type   wr_j;
   btc_pkg::char_type      wr_data;
   btc_pkg::key_entry_type wr_pos;
   btc_pkg::pos_type       wr_idx;

   // Pad letter: step the LFSR, then 'a' + value mod 26 via reciprocal and one correction
   always_comb begin
      lfsr_nx  = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ btc_pkg::LFSR_TAPS) : (lfsr_ff >> 1);
      prod     = btc_pkg::prod_type'(lfsr_nx) * btc_pkg::prod_type'(btc_pkg::MOD_RECIP);
      quot     = btc_pkg::lfsr_type'(prod >> btc_pkg::MOD_SHIFT);
      // 26 = 16 + 8 + 2
      quot_x26 = (quot << 4) + (quot << 3) + (quot << 1);
      rem      = lfsr_nx - quot_x26;
      rem_fix  = (rem >= btc_pkg::PAD_RADIX) ? (rem - btc_pkg::PAD_RADIX) : rem;
      pad_char = btc_pkg::PAD_BASE + btc_pkg::char_type'(rem_fix);
   end

   // Sequencer: next state, buffer placement and output register load
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      lfsr_in      = lfsr_ff;
      blk_mem_in   = blk_mem_ff;
      vld_in       = vld_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_j         = btc_pkg::key_idx_type'(fill_ff);
      wr_data      = q_head.ch;
      wr_pos       = '0;
      wr_idx       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_blk_in   = rsp_blk_ff;
      rsp_msg_in   = rsp_msg_ff;

      slot_free = !rsp_valid_ff || rsp.ready;
      fill_inc  = btc_pkg::cmp_type'(fill_ff) + btc_pkg::cmp_type'(1);
      fill_lt   = btc_pkg::cmp_type'(fill_ff) < btc_pkg::cmp_type'(cfg.size);
      at_end    = (btc_pkg::cmp_type'(pos_ff) + btc_pkg::cmp_type'(1)) ==
                  btc_pkg::cmp_type'(cfg.size);
      emit_go   = ((state_ff == btc_pkg::ST_EMIT) || (state_ff == btc_pkg::ST_FLUSH)) &&
                  slot_free;

      case (state_ff)
         btc_pkg::ST_IDLE: begin
            if (q_status.not_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               if (q_head.kept) begin
                  if (!fill_lt) begin
                     // size was lowered below the fill: flush before placing
                     state_in = btc_pkg::ST_FLUSH;
                     pos_in   = '0;
                     last_in  = 1'b0;
                  end else begin
                     wr_en   = 1'b1;
                     fill_in = btc_pkg::size_type'(fill_inc);
                     if (fill_inc >= btc_pkg::cmp_type'(cfg.size)) begin
                        state_in = btc_pkg::ST_EMIT;
                        pos_in   = '0;
                        last_in  = q_head.eot;
                     end else if (q_head.eot) begin
                        state_in = btc_pkg::ST_PAD;
                     end
                  end
               end else if (q_head.eot && (fill_ff != '0)) begin
                  pos_in  = '0;
                  last_in = 1'b1;
                  state_in = fill_lt ? btc_pkg::ST_PAD : btc_pkg::ST_EMIT;
               end
            end
         end

         btc_pkg::ST_PAD: begin
            lfsr_in = lfsr_nx;
            wr_en   = 1'b1;
            wr_data = pad_char;
            fill_in = btc_pkg::size_type'(fill_inc);
            if (fill_inc >= btc_pkg::cmp_type'(cfg.size)) begin
               state_in = btc_pkg::ST_EMIT;
               pos_in   = '0;
               last_in  = 1'b1;
            end
         end

         btc_pkg::ST_EMIT, btc_pkg::ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = vld_ff[pos_ff] ? blk_mem_ff[pos_ff] : '0;
               rsp_blk_in   = at_end;
               rsp_msg_in   = last_ff && at_end;
               pos_in       = pos_ff + btc_pkg::pos_type'(1);
               if (at_end) begin
                  vld_in  = '0;
                  fill_in = '0;
                  pos_in  = '0;
                  if (state_ff == btc_pkg::ST_EMIT) begin
                     state_in = btc_pkg::ST_IDLE;
                  end else begin
                     // held byte opens the new block
                     wr_en   = 1'b1;
                     wr_j    = '0;
                     wr_data = cur_ff.ch;
                     fill_in = btc_pkg::size_type'(1);
                     if (cur_ff.eot) begin
                        last_in  = 1'b1;
                        state_in = (btc_pkg::cmp_type'(1) < btc_pkg::cmp_type'(cfg.size)) ?
                                   btc_pkg::ST_PAD : btc_pkg::ST_EMIT;
                     end else begin
                        state_in = btc_pkg::ST_IDLE;
                     end
                  end
               end
            end
         end

         default: begin
            state_in = btc_pkg::ST_IDLE;
         end
      endcase

      // Buffer write through the key; entries outside the block are discarded
      wr_pos = cfg.key[wr_j];
      wr_idx = btc_pkg::pos_type'(wr_pos);
      if (wr_en && (btc_pkg::cmp_type'(wr_pos) < btc_pkg::cmp_type'(cfg.size))) begin
         blk_mem_in[wr_idx] = wr_data;
         vld_in[wr_idx]     = 1'b1;
      end

      // Seed write reloads the generator; zero is taken as one
      if (cfg.seed_load) begin
         lfsr_in = (cfg.seed == '0) ? btc_pkg::lfsr_type'(1) : cfg.seed;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btc_pkg::ST_IDLE;
         fill_ff      <= '0;
         pos_ff       <= '0;
         lfsr_ff      <= btc_pkg::SEED_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         lfsr_ff      <= lfsr_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      blk_mem_ff  <= blk_mem_in;
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_msg_ff  <= rsp_msg_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.out_char        = rsp_char_ff;
   assign rsp.last_in_block   = rsp_blk_ff;
   assign rsp.last_of_message = rsp_msg_ff;

   `BTC_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= btc_pkg::size_type'(btc_pkg::MAX_BLOCK), "fill count beyond block capacity")
   `BTC_ASSERT_IMP(a_msg_ends_block, clock, reset, rsp_valid_ff && rsp_msg_ff,
      rsp_blk_ff, "message end flagged inside a block")
   `BTC_ASSERT_NXT(a_buffer_cleared, clock, reset,
      emit_go && at_end && (state_ff == btc_pkg::ST_EMIT),
      vld_ff == '0, "block buffer not cleared after emission")
   `BTC_ASSERT_IMP(a_lfsr_live, clock, reset, 1'b1,
      lfsr_ff != '0, "padding generator stuck at zero")

endmodule

`default_nettype wire

>>> rtl/block_transposition_cipher.sv
// Top level of the block transposition cipher: register file, front end, queue, block engine.
// Depends on btc_pkg, btc_intf, btc_front, btc_queue and btc_back.
`default_nettype none

// Text bytes enter on req_ch one transaction per cycle while the queue is not full; blanks and
// newlines are dropped and capitals folded to lower case. The j-th kept byte of a block lands
// at the buffer position named by key entry j, and a full block leaves on rsp_ch in position
// order, one byte per cycle while the receiver is ready, with last_in_block on its final byte.
// A transaction flagged end_of_text pads any partial block with LFSR letters and flushes it,
// setting last_of_message on the final byte. A kept byte that does not close a block is only
// placed; a byte that closes a block is placed and the block emitted, and an end of text adds
// the pad letters and the emission of the padded block. Throughput is set by the single read
// port of the block buffer, which emits one byte per cycle while the receiver is ready; the
// engine works on one transaction at a time. A two-entry queue lets the front keep accepting
// while the engine emits. Registers: 0 block_size, 1 key_positions, 2 pad_seed (a write
// reloads the padding LFSR); write them only while the block is idle.
module block_transposition_cipher (
   input logic         clock,
   input logic         reset,
   btc_req_if.sink     req_ch,
   btc_rsp_if.source   rsp_ch,
   btc_csr_if.sink     csr_ch
);

   btc_pkg::csr_size_type     size_raw_ff, size_raw_in;
   btc_pkg::key_type          key_ff,      key_in;
   logic                      seed_load;
   btc_pkg::cfg_type          cfg;
   btc_pkg::queue_status_type q_status;
   btc_pkg::item_type         push_item;
   btc_pkg::item_type         q_head;
   logic                      q_push;
   logic                      q_pop;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      size_raw_in = size_raw_ff;
      key_in      = key_ff;
      seed_load   = 1'b0;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            btc_pkg::REG_BLOCK_SIZE:    size_raw_in = csr_ch.data[btc_pkg::CSR_SIZE_W-1:0];
            btc_pkg::REG_KEY_POSITIONS: key_in      = btc_pkg::key_type'(csr_ch.data);
            btc_pkg::REG_PAD_SEED:      seed_load   = 1'b1;
            default:                    seed_load   = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_raw_ff <= btc_pkg::BLOCK_SIZE_RESET;
         key_ff      <= btc_pkg::KEY_RESET;
      end else begin
         size_raw_ff <= size_raw_in;
         key_ff      <= key_in;
      end
   end

   // Effective block size: zero acts as one, oversize clamps to capacity
   always_comb begin
      if (size_raw_ff == '0) begin
         cfg.size = btc_pkg::size_type'(1);
      end else if (size_raw_ff > btc_pkg::MAX_BLOCK) begin
         cfg.size = btc_pkg::size_type'(btc_pkg::MAX_BLOCK);
      end else begin
         cfg.size = btc_pkg::size_type'(size_raw_ff);
      end
      cfg.key       = key_ff;
      cfg.seed_load = seed_load;
      cfg.seed      = csr_ch.data[btc_pkg::LFSR_W-1:0];
   end

   btc_front u_front (
      .req      (req_ch),
      .q_status (q_status),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   btc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   btc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_status (q_status),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

>>> sim/tb_block_transposition_cipher.sv
// Self-checking testbench for the block transposition cipher: a directed table, then random text.
// Depends on btc_pkg, the btc_req_if / btc_rsp_if / btc_csr_if interfaces and the cipher top.
`timescale 1ns / 100ps

module tb_block_transposition_cipher;
   import btc_pkg::*;

   localparam int            SETTLE_CYCLES = 40;    // engine drain after the last result
   localparam int            HOLD_CYCLES   = 200;   // long receiver hold-off
   localparam int            STALL_LIMIT   = 3000;  // cycles with no transaction at all
   localparam int            RANDOM_ITEMS  = 345;
   localparam int            MAX_REPORTS   = 50;
   localparam csr_index_type REG_SPARE     = 2'd3;  // unmapped register index

   typedef enum logic {ROW_TEXT, ROW_CSR} row_kind_type;

   // One row of the directed table; gold holds up to eight typed ciphertext bytes
   typedef struct packed {
      row_kind_type  kind;
      csr_index_type idx;
      csr_data_type  data;
      char_type      ch;
      logic          eot;
      logic [63:0]   gold;
      logic [3:0]    gold_n;
   } row_type;

   typedef struct packed {
      logic [63:0] str;
      logic [3:0]  n;
   } golden_type;

   typedef struct packed {
      char_type ch;
      logic     lib;
      logic     lom;
   } cipher_byte_type;

   localparam int DIR_ROWS = 37;

   logic clock;
   logic reset;

   btc_req_if req_ch();
   btc_rsp_if rsp_ch();
   btc_csr_if csr_ch();

   block_transposition_cipher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Cipher state mirrored by the predictor
   char_type     blk_buf [16];
   int unsigned  fill_cnt;
   lfsr_type     pad_reg;
   csr_size_type size_reg;
   key_type      key_reg;
   lfsr_type     seed_reg;

   cipher_byte_type ciphertext_q [$];
   golden_type      golden_q [$];

   int   mismatch_count = 0;
   int   idle_pct       = 27;
   int   stall_pct      = 27;
   logic hold_req       = 1'b0;
   int   msg_left       = 0;

   row_type dir_rows [DIR_ROWS];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic void clear_cipher_state();
      foreach (blk_buf[p]) blk_buf[p] = '0;
      fill_cnt = 0;
      size_reg = BLOCK_SIZE_RESET;
      key_reg  = KEY_RESET;
      seed_reg = SEED_RESET;
      pad_reg  = SEED_RESET;
   endfunction

   function automatic int unsigned live_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_BLOCK) return MAX_BLOCK;
      return size_reg;
   endfunction

   function automatic void apply_register(csr_index_type idx, csr_data_type d);
      case (idx)
         REG_BLOCK_SIZE:    size_reg = d[4:0];
         REG_KEY_POSITIONS: key_reg  = d;
         REG_PAD_SEED: begin
            seed_reg = d[15:0];
            pad_reg  = (seed_reg == 0) ? lfsr_type'(1) : seed_reg;
         end
         default: ;
      endcase
   endfunction

   // Galois step first, then the new value picks the letter
   function automatic char_type next_pad();
      lfsr_type v;
      v = pad_reg;
      if (v[0]) v = (v >> 1) ^ LFSR_TAPS;
      else v = v >> 1;
      pad_reg = v;
      return PAD_BASE + char_type'(v % PAD_RADIX);
   endfunction

   // Entries pointing past the block drop the byte
   function automatic void place_char(int unsigned j, char_type c, int unsigned sz);
      int unsigned pos;
      pos = key_reg[j & 15];
      if (pos < sz) blk_buf[pos] = c;
   endfunction

   function automatic void flush_block(int unsigned sz, logic last_msg);
      for (int unsigned p = 0; p < sz; p++)
         ciphertext_q.push_back('{blk_buf[p], p + 1 == sz, last_msg && (p + 1 == sz)});
      foreach (blk_buf[p]) blk_buf[p] = '0;
      fill_cnt = 0;
   endfunction

   function automatic void cipher_step(char_type raw, logic eot);
      char_type    c;
      int unsigned sz;
      int unsigned n;
      c  = raw;
      sz = live_size();
      n  = 0;
      if (c != CHAR_SPACE && c != CHAR_NEWLINE) begin
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = c + CASE_OFFSET;
         // size was lowered under a partial block: flush it first
         if (fill_cnt >= sz) begin
            flush_block(sz, 1'b0);
            n = sz;
         end
         place_char(fill_cnt, c, sz);
         fill_cnt++;
         if (fill_cnt >= sz && n == 0) begin
            flush_block(sz, eot);
            return;
         end
         if (fill_cnt >= sz) fill_cnt = sz;
      end
      if (eot) begin
         if (fill_cnt > 0) begin
            for (int unsigned j = fill_cnt; j < sz; j++) place_char(j, next_pad(), sz);
            flush_block(sz, 1'b1);
         end else if (n > 0) begin
            ciphertext_q[ciphertext_q.size() - 1].lom = 1'b1;
         end
      end
   endfunction

   // ---------------------------------------------------------------- monitor and watchdog
   always @(posedge clock) begin : monitor
      cipher_byte_type want;
      golden_type      g;
      int              base;
      int              made;
      int              quiet;
      if (reset) begin
         quiet = 0;
      end else begin
         // results first: nothing accepted on this edge can show up on it
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (ciphertext_q.size() == 0) begin
               report_mismatch("byte with nothing expected", rsp_ch.out_char, 8'h00);
            end else begin
               want = ciphertext_q.pop_front();
               if (rsp_ch.out_char !== want.ch)
                  report_mismatch("out_char", rsp_ch.out_char, want.ch);
               if (rsp_ch.last_in_block !== want.lib)
                  report_mismatch("last_in_block", 8'(rsp_ch.last_in_block), 8'(want.lib));
               if (rsp_ch.last_of_message !== want.lom)
                  report_mismatch("last_of_message", 8'(rsp_ch.last_of_message),
                                  8'(want.lom));
            end
         end
         if (csr_ch.valid && csr_ch.ready) apply_register(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) begin
            g    = golden_q.pop_front();
            base = ciphertext_q.size();
            cipher_step(req_ch.in_char, req_ch.end_of_text);
            made = ciphertext_q.size() - base;
            // typed rows replace the predicted bytes
            if (g.n != 0) begin
               if (made != int'(g.n))
                  report_mismatch("directed block length", 8'(made), 8'(g.n));
               else
                  for (int i = 0; i < made; i++)
                     ciphertext_q[base + i].ch = g.str[8 * (int'(g.n) - 1 - i) +: 8];
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   initial begin : receiver
      logic hold_seen;
      hold_seen = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            rsp_ch.ready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- driver tasks
   task automatic send_text(char_type c, logic eot, logic [63:0] gold, logic [3:0] gold_n);
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      golden_q.push_back('{gold, gold_n});
      req_ch.valid       <= 1'b1;
      req_ch.in_char     <= c;
      req_ch.end_of_text <= eot;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_register(csr_index_type idx, csr_data_type d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= d;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every expected byte, then let silent transactions drain
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (ciphertext_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic row_type text_row(char_type c, logic eot,
                                        logic [63:0] gold = '0, int gn = 0);
      return '{ROW_TEXT, REG_BLOCK_SIZE, '0, c, eot, gold, 4'(gn)};
   endfunction

   function automatic row_type csr_row(csr_index_type idx, csr_data_type d);
      return '{ROW_CSR, idx, d, '0, 1'b0, '0, 4'd0};
   endfunction

   // Mostly a permutation of the live block, the rest of the entries random
   function automatic key_type random_key(int unsigned sz);
      int      perm [16];
      int      k;
      int      t;
      key_type key;
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      for (int i = 0; i < 16; i++) perm[i] = i;
      for (int i = int'(sz) - 1; i > 0; i--) begin
         k       = $urandom_range(0, i);
         t       = perm[i];
         perm[i] = perm[k];
         perm[k] = t;
      end
      for (int j = 0; j < 16; j++)
         key[j] = (j < int'(sz)) ? key_entry_type'(perm[j])
                                 : key_entry_type'($urandom_range(0, 15));
      return key;
   endfunction

   task automatic configure_random();
      csr_size_type s;
      csr_data_type d;
      int unsigned  eff;
      case ($urandom_range(0, 9))
         0:       s = 5'd0;
         1:       s = 5'($urandom_range(17, 31));
         2:       s = 5'd16;
         3:       s = 5'd1;
         default: s = 5'($urandom_range(2, 8));
      endcase
      d      = {$urandom, $urandom};
      d[4:0] = s;
      write_register(REG_BLOCK_SIZE, d);
      eff = (s == 0) ? 1 : (s > MAX_BLOCK) ? MAX_BLOCK : s;
      write_register(REG_KEY_POSITIONS, random_key(eff));
      if ($urandom_range(0, 1) == 1)
         write_register(REG_PAD_SEED, ($urandom_range(0, 9) == 0) ? '0 :
                        csr_data_type'($urandom_range(0, 65535)));
   endtask

   // Mostly letters with blanks, a share of arbitrary bytes
   function automatic char_type random_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return char_type'($urandom_range(8'h61, 8'h7A));
      if (r < 65) return char_type'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
      if (r < 75) return CHAR_SPACE;
      if (r < 80) return CHAR_NEWLINE;
      if (r < 90) return char_type'($urandom_range(8'h21, 8'h7E));
      return char_type'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------- main sequence
   initial begin : driver
      int   sent;
      int   phase;
      int   burst;
      logic eot;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.in_char     <= '0;
      req_ch.end_of_text <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= REG_BLOCK_SIZE;
      csr_ch.data        <= '0;
      clear_cipher_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      dir_rows = '{
         // reset settings: identity key, five per block
         text_row("H", 1'b0), text_row(CHAR_SPACE, 1'b0), text_row("e", 1'b0),
         text_row(CHAR_NEWLINE, 1'b0), text_row("L", 1'b0), text_row("l", 1'b0),
         text_row("O", 1'b0, "hello", 5), text_row("Z", 1'b1),
         // unmapped index, then size zero acting as one
         csr_row(REG_SPARE, 64'h5A5A_A5A5_0F0F_F0F0),
         csr_row(REG_BLOCK_SIZE, 64'hFFFF_FFFF_FFFF_FFE0),
         text_row(8'hFF, 1'b0), text_row(8'h00, 1'b1),
         // oversize block, reversed key, zero seed; heavy padding
         csr_row(REG_BLOCK_SIZE, 64'h1F), csr_row(REG_KEY_POSITIONS, 64'h0123_4567_89AB_CDEF),
         csr_row(REG_PAD_SEED, '0),
         text_row(8'h40, 1'b0), text_row(8'h5B, 1'b0), text_row("A", 1'b0),
         text_row("z", 1'b0), text_row(8'h7F, 1'b1),
         // every key entry outside the block: all zero bytes
         csr_row(REG_PAD_SEED, 64'hFFFF), csr_row(REG_BLOCK_SIZE, 64'd4),
         csr_row(REG_KEY_POSITIONS, '1), text_row("w", 1'b0), text_row("x", 1'b1),
         // block size lowered under a partial block
         csr_row(REG_BLOCK_SIZE, 64'd8), csr_row(REG_KEY_POSITIONS, KEY_RESET),
         text_row("q", 1'b0), text_row("r", 1'b0), text_row("s", 1'b0),
         csr_row(REG_BLOCK_SIZE, 64'd2), text_row("t", 1'b0, "qr", 2),
         text_row("u", 1'b1, "tu", 2), text_row("k", 1'b0),
         csr_row(REG_BLOCK_SIZE, 64'd1), text_row("M", 1'b1, "km", 2),
         // empty message
         text_row(CHAR_SPACE, 1'b1)
      };

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_block();
            write_register(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_text(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].gold, dir_rows[i].gold_n);
         end
      end

      // Random phases; a phase may end mid-message so settings change under a partial block
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain_block();
         configure_random();
         burst = $urandom_range(20, 45);
         if (phase == 2) begin
            idle_pct  = 0;
            stall_pct = 0;
            burst     = 60;
         end else if (phase == 4) begin
            idle_pct  = 0;
            hold_req <= ~hold_req;
            burst     = 60;
         end
         for (int i = 0; i < burst; i++) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                      : $urandom_range(1, 24);
            eot = (msg_left == 1);
            msg_left--;
            send_text(random_char(), eot, '0, 4'd0);
            sent++;
         end
         idle_pct  = 27;
         stall_pct = 27;
         phase++;
      end

      drain_block();
      if (mismatch_count == 0 && ciphertext_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
